// ----- sv/ndd_pkg.sv -----
package ndd_pkg;

  localparam int unsigned TimeBits = 32;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CfgSourceId     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBeaconsWake  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNormalSleep  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgActiveSleep  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAggrTimeout  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAckWindow    = 3'd5;

  localparam logic [1:0] CodeNormal = 2'd0;
  localparam logic [1:0] CodeAggr   = 2'd1;
  localparam logic [1:0] CodeAck    = 2'd2;
  localparam logic [1:0] CodeDone   = 2'd3;

  localparam logic RxSlotTick = 1'b0;

  typedef enum logic [3:0] {
    ModeNormal = 4'b0001,
    ModeAggr   = 4'b0010,
    ModeAck    = 4'b0100,
    ModeDone   = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [15:0] source_id;
    logic [3:0]  beacons_per_wake;
    logic [7:0]  normal_sleep_slots;
    logic [7:0]  active_sleep_slots;
    logic [15:0] aggressive_timeout_slots;
    logic [15:0] ack_window_slots;
  } ndd_cfg_t;

  typedef struct packed {
    mode_e               mode;
    logic                ack_window_open;
    logic [TimeBits-1:0] slot_clock;
    logic [TimeBits-1:0] aggr_start;
    logic [TimeBits-1:0] ack_start;
    logic [31:0]         seq;
    logic [2:0]          beacon_index;
    logic [7:0]          sleep_left;
    logic                in_sleep;
    logic                halted;
    logic                hdr_phase;
    logic                hdr_ack;
  } ndd_state_t;

  typedef struct packed {
    logic req_type;
    logic rx_length_ok;
    logic rx_ack_flag;
  } ndd_req_t;

  typedef struct packed {
    logic        beacon_valid;
    logic [15:0] beacon_source;
    logic [31:0] beacon_seq;
    logic [31:0] beacon_time;
    logic        beacon_phase;
    logic        beacon_ack;
    logic        radio_enabled;
    logic [1:0]  mode_now;
  } ndd_res_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    case (m)
      ModeNormal: c = CodeNormal;
      ModeAggr:   c = CodeAggr;
      ModeAck:    c = CodeAck;
      ModeDone:   c = CodeDone;
      default:    c = CodeNormal;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/ndd_step.sv -----
module ndd_step (
  input  ndd_pkg::ndd_state_t state_i,
  input  ndd_pkg::ndd_cfg_t   cfg_i,
  input  ndd_pkg::ndd_req_t   req_i,
  output ndd_pkg::ndd_state_t state_o,
  output ndd_pkg::ndd_res_t   res_o
);
  import ndd_pkg::*;

  ndd_state_t st;
  ndd_res_t   res;
  logic       send;
  logic [3:0] bpw;
  logic [3:0] next_idx;
  logic [7:0] sleep_cnt;

  always_comb begin
    st        = state_i;
    res       = '0;
    send      = 1'b0;
    bpw       = cfg_i.beacons_per_wake;
    next_idx  = {1'b0, state_i.beacon_index} + 4'd1;
    sleep_cnt = 8'd1;

    if (bpw == 4'd0) begin
      bpw = 4'd1;
    end else if (bpw > 4'd8) begin
      bpw = 4'd8;
    end

    if (req_i.req_type != RxSlotTick) begin
      if (req_i.rx_length_ok && !st.halted) begin
        case (st.mode)
          ModeNormal: begin
            st.mode       = ModeAggr;
            st.aggr_start = st.slot_clock;
          end
          ModeAggr: begin
            if (req_i.rx_ack_flag) begin
              st.mode = ModeDone;
            end else if (!st.ack_window_open) begin
              st.mode            = ModeAck;
              st.ack_start       = st.slot_clock;
              st.ack_window_open = 1'b1;
            end
          end
          ModeAck: begin
            if (req_i.rx_ack_flag) begin
              st.mode = ModeDone;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      if (!st.halted) begin
        if (st.in_sleep) begin
          if (st.sleep_left != 8'd0) begin
            st.sleep_left = st.sleep_left - 8'd1;
          end
          if (st.sleep_left == 8'd0) begin
            st.in_sleep = 1'b0;
          end
        end
        if (!st.in_sleep) begin
          if (st.beacon_index == 3'd0) begin
            if (st.mode == ModeDone) begin
              st.halted = 1'b1;
            end else begin
              st.hdr_ack   = (st.mode == ModeAck);
              st.hdr_phase = (st.mode != ModeNormal);
              send         = 1'b1;
            end
          end else begin
            send = 1'b1;
          end
        end
        if (send) begin
          st.seq                = st.seq + 32'd1;
          res.beacon_valid      = 1'b1;
          res.beacon_source     = cfg_i.source_id;
          res.beacon_seq        = st.seq;
          res.beacon_time       = 32'(st.slot_clock);
          res.beacon_phase      = st.hdr_phase;
          res.beacon_ack        = st.hdr_ack;
          if (next_idx >= bpw) begin
            // end of wake: pick sleep length before the timeout checks
            sleep_cnt = (st.mode == ModeNormal) ? cfg_i.normal_sleep_slots
                                                : cfg_i.active_sleep_slots;
            if (sleep_cnt == 8'd0) begin
              sleep_cnt = 8'd1;
            end
            if (st.mode == ModeAggr) begin
              if ((st.slot_clock - st.aggr_start) >=
                  TimeBits'(cfg_i.aggressive_timeout_slots)) begin
                st.mode = ModeNormal;
              end
            end else if (st.mode == ModeAck) begin
              if ((st.slot_clock - st.ack_start) >= TimeBits'(cfg_i.ack_window_slots)) begin
                st.mode            = ModeDone;
                st.ack_window_open = 1'b0;
              end
            end
            st.sleep_left   = sleep_cnt;
            st.in_sleep     = 1'b1;
            st.beacon_index = 3'd0;
          end else begin
            st.beacon_index = next_idx[2:0];
          end
        end
      end
      st.slot_clock = st.slot_clock + TimeBits'(1);
    end

    res.radio_enabled = !st.halted && !st.in_sleep && (st.beacon_index != 3'd0);
    res.mode_now      = mode_code(st.mode);
  end

  assign state_o = st;
  assign res_o   = res;

endmodule

// ----- sv/neighbour_discovery_duty_cycle_fsm.sv -----
// flow: an accepted request is held in the request register; its result enters the output register once that is free
// throughput: one request per cycle while the result register is not stalled; the combinational state update sets this
// input stalls only while a request is held and the result register is stalled
// reset (rst_ni low, asynchronous) clears mode, timers, counters and handshake state
// and loads the configuration defaults
module neighbour_discovery_duty_cycle_fsm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ndd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic                         rx_length_ok_i,
  input  logic                         rx_ack_flag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         beacon_valid_o,
  output logic [15:0]                  beacon_source_o,
  output logic [31:0]                  beacon_seq_o,
  output logic [31:0]                  beacon_time_o,
  output logic                         beacon_phase_o,
  output logic                         beacon_ack_o,
  output logic                         radio_enabled_o,
  output logic [1:0]                   mode_now_o
);
  import ndd_pkg::*;

  ndd_cfg_t   cfg_q;
  ndd_state_t state_q;
  ndd_state_t state_d;
  ndd_req_t   req_q;
  ndd_res_t   res_d;
  ndd_res_t   res_q;
  logic       req_valid_q;
  logic       out_valid_q;
  logic       out_free;
  logic       step_fire;
  logic       in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_fire  = req_valid_q && out_free;
  assign in_stall_o = req_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_id                <= 16'd0;
      cfg_q.beacons_per_wake         <= 4'd2;
      cfg_q.normal_sleep_slots       <= 8'd8;
      cfg_q.active_sleep_slots       <= 8'd1;
      cfg_q.aggressive_timeout_slots <= 16'd100;
      cfg_q.ack_window_slots         <= 16'd20;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSourceId:    cfg_q.source_id                <= cfg_wdata_i;
        CfgBeaconsWake: cfg_q.beacons_per_wake         <= cfg_wdata_i[3:0];
        CfgNormalSleep: cfg_q.normal_sleep_slots       <= cfg_wdata_i[7:0];
        CfgActiveSleep: cfg_q.active_sleep_slots       <= cfg_wdata_i[7:0];
        CfgAggrTimeout: cfg_q.aggressive_timeout_slots <= cfg_wdata_i;
        CfgAckWindow:   cfg_q.ack_window_slots         <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        req_valid_q <= 1'b1;
      end else if (step_fire) begin
        req_valid_q <= 1'b0;
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.req_type     <= req_type_i;
      req_q.rx_length_ok <= rx_length_ok_i;
      req_q.rx_ack_flag  <= rx_ack_flag_i;
    end
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  ndd_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .req_i   (req_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= {ModeNormal, {($bits(ndd_state_t) - $bits(mode_e)){1'b0}}};
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign beacon_valid_o  = res_q.beacon_valid;
  assign beacon_source_o = res_q.beacon_source;
  assign beacon_seq_o    = res_q.beacon_seq;
  assign beacon_time_o   = res_q.beacon_time;
  assign beacon_phase_o  = res_q.beacon_phase;
  assign beacon_ack_o    = res_q.beacon_ack;
  assign radio_enabled_o = res_q.radio_enabled;
  assign mode_now_o      = res_q.mode_now;

`ifndef SYNTH
  // halting is final
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.halted |=> state_q.halted)
    else $error("halted state cleared");

  a_halt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.halted |-> state_q.mode == ModeDone)
    else $error("halted outside complete mode");

  a_sleep_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_sleep |-> state_q.beacon_index == 3'd0)
    else $error("sleeping in the middle of a wake");

  a_ack_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ack_window_open |-> (state_q.mode == ModeAck || state_q.mode == ModeDone))
    else $error("ack window open outside ack or complete mode");
`endif

endmodule
